/* rtl/huffman_bit_packer_core_macros.svh */
// ----------------------------------------------------------------------------
// Huffman bit packer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_PACKER_CORE_MACROS_SVH
`define HUFFMAN_BIT_PACKER_CORE_MACROS_SVH

// Same-cycle implication.
`define HBP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("huffman_bit_packer_core: same-cycle check failed");

// Next-cycle implication.
`define HBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("huffman_bit_packer_core: next-cycle check failed");

`endif

/* rtl/hbp_pkg.sv */
// ----------------------------------------------------------------------------
// hbp_pkg
// Types and constants of the Huffman bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hbp_pkg;

    localparam int BYTE_WIDTH       = 8;
    localparam int SYM_WIDTH        = 8;
    localparam int WORD_IN_WIDTH    = 32;
    localparam int LEN_IN_WIDTH     = 6;
    localparam int OP_WIDTH         = 2;
    localparam int TABLE_DEPTH      = 256;

    // Request payload layout in s_tdata.
    localparam int SYM_LSB          = 0;
    localparam int WORD_LSB         = SYM_LSB + SYM_WIDTH;
    localparam int LEN_LSB          = WORD_LSB + WORD_IN_WIDTH;
    localparam int S_TDATA_WIDTH    = ((LEN_LSB + LEN_IN_WIDTH + 7) / 8) * 8;

    // Result flags in m_tuser.
    localparam int M_TUSER_WIDTH    = 2;
    localparam int UBIT_BYTE_VALID  = 0;
    localparam int UBIT_MISS        = 1;

    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_COUNT_WIDTH  = 48;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_WRITE  = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FINISH = 2'd2
    } hbp_op_t;

endpackage

`default_nettype wire

/* rtl/huffman_bit_packer_core.sv */
// ----------------------------------------------------------------------------
// huffman_bit_packer_core
// Table-driven Huffman encoder that packs code bits into bytes.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the operation (write a
// table entry, encode a symbol, finish), s_tdata the symbol, code word and
// code length. Table writes produce no result. Results leave on the m_
// stream, at most one packed byte per result, with m_tlast on the last
// result of a request. Finish results also carry the saturating bit total.
// A request passes an input register, where the code table memory is read,
// and then the result register, which drives m_tvalid. One request is taken
// per cycle while results drain and no full bytes wait in the packing stage.
// A symbol that completes more than one byte holds the packing stage until
// all are out, one byte per cycle through the byte-wide result register while
// the receiver takes them; misses, finishes and symbols with no byte do not.
// At reset all table entries become unwritten and the partial byte and the
// bit total are cleared; the table contents themselves are not cleared.
// When the receiver stalls, the result register holds, the packing stage
// waits, and s_tready falls once the input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_bit_packer_core_macros.svh"

module huffman_bit_packer_core
    import hbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
    parameter int M_TDATA_WIDTH = ((BYTE_WIDTH + COUNT_WIDTH + 7) / 8) * 8
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      s_tvalid,
    output      logic                      s_tready,
    // symbol[7:0], code_word[39:8], code_length[45:40], zero pad above
    input  wire logic [S_TDATA_WIDTH-1:0]  s_tdata,
    // op[1:0]
    input  wire logic [OP_WIDTH-1:0]       s_tuser,

    output      logic                      m_tvalid,
    input  wire logic                      m_tready,
    // out_byte[7:0], total_bits[COUNT_WIDTH+7:8], zero pad above
    output      logic [M_TDATA_WIDTH-1:0]  m_tdata,
    // byte_valid[0], miss_error[1]
    output      logic [M_TUSER_WIDTH-1:0]  m_tuser,
    output      logic                      m_tlast
);

    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int BW = MAX_CODE_LEN + BYTE_WIDTH - 1;
    localparam int CW = $clog2(BW + 1);
    localparam int EW = LW + MAX_CODE_LEN;

    // Request decode.
    logic                      s_accept;
    hbp_op_t                   in_op;
    logic [SYM_WIDTH-1:0]      in_sym;
    logic [WORD_IN_WIDTH-1:0]  in_word;
    logic [LEN_IN_WIDTH-1:0]   in_len;
    logic [LW-1:0]             wr_len;
    logic [MAX_CODE_LEN-1:0]   word_ext;
    logic [MAX_CODE_LEN-1:0]   wr_word;

    assign s_accept = s_tvalid && s_tready;
    assign in_op    = hbp_op_t'(s_tuser);
    assign in_sym   = s_tdata[SYM_LSB +: SYM_WIDTH];
    assign in_word  = s_tdata[WORD_LSB +: WORD_IN_WIDTH];
    assign in_len   = s_tdata[LEN_LSB +: LEN_IN_WIDTH];
    assign word_ext = MAX_CODE_LEN'(in_word);

    always_comb
    begin
        if (int'(in_len) > MAX_CODE_LEN)
        begin
            wr_len = LW'(MAX_CODE_LEN);
        end
        else
        begin
            wr_len = LW'(in_len);
        end
        for (int i = 0; i < MAX_CODE_LEN; i++)
        begin
            wr_word[i] = word_ext[i] && (i < int'(wr_len));
        end
    end

    // Code table memory and its written flags.
    logic [EW-1:0]            code_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   entry_valid_reg;
    logic                     wr_en;
    logic                     rd_en;

    assign wr_en = s_accept && (in_op == OP_WRITE);
    assign rd_en = s_accept && ((in_op == OP_ENCODE) || (in_op == OP_FINISH));

    // Input stage registers.
    logic                     a_valid_reg;
    hbp_op_t                  a_op_reg;
    logic                     a_hit_reg;
    logic [MAX_CODE_LEN-1:0]  a_word_reg;
    logic [LW-1:0]            a_len_reg;
    logic                     a_advance;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_mem[in_sym] <= {wr_len, wr_word};
        end
        if (rd_en)
        begin
            {a_len_reg, a_word_reg} <= code_mem[in_sym];
            a_op_reg                <= in_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            a_valid_reg     <= 1'b0;
            a_hit_reg       <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[in_sym] <= 1'b1;
            end
            if (rd_en)
            begin
                a_hit_reg <= entry_valid_reg[in_sym];
            end
            if (s_accept)
            begin
                a_valid_reg <= rd_en;
            end
            else if (a_advance)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = !a_valid_reg || a_advance;

    // Packing stage: the bit buffer is left aligned, and bits below the
    // count are always zero so a finish byte needs no extra padding logic.
    logic [BW-1:0]           buf_reg,   buf_next;
    logic [CW-1:0]           cnt_reg,   cnt_next;
    logic [COUNT_WIDTH-1:0]  total_reg, total_next;
    logic [CW-1:0]           place_shift;
    logic [BW-1:0]           merged;
    logic [CW-1:0]           mcnt;
    logic [COUNT_WIDTH:0]    total_sum;
    logic                    out_free;

    // Result register.
    logic                    m_valid_reg, m_valid_next;
    logic [BYTE_WIDTH-1:0]   o_byte_reg,  o_byte_next;
    logic                    o_bval_reg,  o_bval_next;
    logic                    o_last_reg,  o_last_next;
    logic [COUNT_WIDTH-1:0]  o_total_reg, o_total_next;
    logic                    o_miss_reg,  o_miss_next;
    logic                    load;

    assign out_free    = !m_valid_reg || m_tready;
    assign place_shift = CW'(BW) - cnt_reg - CW'(a_len_reg);
    assign merged      = buf_reg | (BW'(a_word_reg) << place_shift);
    assign mcnt        = cnt_reg + CW'(a_len_reg);
    assign total_sum   = {1'b0, total_reg} + (COUNT_WIDTH + 1)'(a_len_reg);

    always_comb
    begin
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        a_advance    = 1'b0;
        load         = 1'b0;
        o_byte_next  = o_byte_reg;
        o_bval_next  = o_bval_reg;
        o_last_next  = o_last_reg;
        o_total_next = o_total_reg;
        o_miss_next  = o_miss_reg;

        if (out_free)
        begin
            if (int'(cnt_reg) >= BYTE_WIDTH)
            begin
                // Drain the remaining full bytes of the current symbol.
                load         = 1'b1;
                o_byte_next  = buf_reg[BW-1 -: BYTE_WIDTH];
                o_bval_next  = 1'b1;
                o_last_next  = int'(cnt_reg) < 2 * BYTE_WIDTH;
                o_total_next = '0;
                o_miss_next  = 1'b0;
                buf_next     = buf_reg << BYTE_WIDTH;
                cnt_next     = cnt_reg - CW'(BYTE_WIDTH);
            end
            else if (a_valid_reg)
            begin
                a_advance = 1'b1;
                case (a_op_reg)
                    OP_ENCODE:
                    begin
                        if (!a_hit_reg)
                        begin
                            load         = 1'b1;
                            o_byte_next  = '0;
                            o_bval_next  = 1'b0;
                            o_last_next  = 1'b1;
                            o_total_next = '0;
                            o_miss_next  = 1'b1;
                        end
                        else
                        begin
                            if (total_sum[COUNT_WIDTH])
                            begin
                                total_next = '1;
                            end
                            else
                            begin
                                total_next = total_sum[COUNT_WIDTH-1:0];
                            end
                            if (int'(mcnt) >= BYTE_WIDTH)
                            begin
                                load         = 1'b1;
                                o_byte_next  = merged[BW-1 -: BYTE_WIDTH];
                                o_bval_next  = 1'b1;
                                o_last_next  = int'(mcnt) < 2 * BYTE_WIDTH;
                                o_total_next = '0;
                                o_miss_next  = 1'b0;
                                buf_next     = merged << BYTE_WIDTH;
                                cnt_next     = mcnt - CW'(BYTE_WIDTH);
                            end
                            else
                            begin
                                buf_next = merged;
                                cnt_next = mcnt;
                            end
                        end
                    end
                    OP_FINISH:
                    begin
                        load         = 1'b1;
                        o_byte_next  = buf_reg[BW-1 -: BYTE_WIDTH];
                        o_bval_next  = (cnt_reg != '0);
                        o_last_next  = 1'b1;
                        o_total_next = total_reg;
                        o_miss_next  = 1'b0;
                        buf_next     = '0;
                        cnt_next     = '0;
                        total_next   = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= '0;
            cnt_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_byte_reg  <= o_byte_next;
        o_bval_reg  <= o_bval_next;
        o_last_reg  <= o_last_next;
        o_total_reg <= o_total_next;
        o_miss_reg  <= o_miss_next;
    end

    always_comb
    begin
        m_tdata                                 = '0;
        m_tdata[BYTE_WIDTH-1:0]                 = o_byte_reg;
        m_tdata[BYTE_WIDTH +: COUNT_WIDTH]      = o_total_reg;
        m_tuser                                 = '0;
        m_tuser[UBIT_BYTE_VALID]                = o_bval_reg;
        m_tuser[UBIT_MISS]                      = o_miss_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = o_last_reg;

    // A finish clears the running state.
    `HBP_ASSERT_NEXT(a_finish_clears, a_advance && (a_op_reg == OP_FINISH),
        (cnt_reg == '0) && (total_reg == '0))
    // A waiting request keeps what it read at accept. An entry that was never
    // written holds undefined data, so the code is compared only on a hit.
    `HBP_ASSERT_NEXT(a_stage_holds, a_valid_reg && !a_advance,
        a_valid_reg && $stable(a_op_reg) && $stable(a_hit_reg)
        && (!a_hit_reg || ($stable(a_word_reg) && $stable(a_len_reg))))
    // A miss result carries no byte and ends its request.
    `HBP_ASSERT_IMPLY(a_miss_shape, m_valid_reg && o_miss_reg,
        !o_bval_reg && o_last_reg && (o_byte_reg == '0))
    // The packing stage takes no new request while full bytes remain.
    `HBP_ASSERT_IMPLY(a_no_take_while_draining, int'(cnt_reg) >= BYTE_WIDTH,
        !a_advance)

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for huffman_bit_packer_core.
// ----------------------------------------------------------------------------
// Requests (table writes, symbol encodes, finishes and the unused opcode)
// are queued by an initial block and driven by a clocked driver with random
// gaps. A packing predictor tracks the code table, the partial byte and the
// bit count, and queues the results each accepted request should produce.
// A clocked monitor checks every result against the oldest queued one while
// the receiver stalls at random, including two long hold-offs.
// ----------------------------------------------------------------------------
module tb;
    import hbp_pkg::*;

    localparam int M_TDATA_W = ((BYTE_WIDTH + DEF_COUNT_WIDTH + 7) / 8) * 8;
    localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
    localparam logic [DEF_COUNT_WIDTH-1:0] TOTAL_MAX = '1;
    localparam int TARGET_ITEMS = 420;
    localparam int LONG_HOLD    = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic [OP_WIDTH-1:0]      op;
        logic [SYM_WIDTH-1:0]     sym;
        logic [WORD_IN_WIDTH-1:0] word;
        logic [LEN_IN_WIDTH-1:0]  len;
        int unsigned              gap;
        bit                       drain_first;
    } pack_req_t;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0]      out_byte;
        logic                       byte_valid;
        logic                       last;
        logic [DEF_COUNT_WIDTH-1:0] total;
        logic                       miss;
    } pack_res_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic [OP_WIDTH-1:0]      s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic [M_TUSER_WIDTH-1:0] m_tuser;
    logic                     m_tlast;

    huffman_bit_packer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Packing predictor state.
    logic [WORD_IN_WIDTH-1:0]   code_words [TABLE_DEPTH];
    int unsigned                code_lens  [TABLE_DEPTH];
    bit                         code_set   [TABLE_DEPTH];
    logic [BYTE_WIDTH-1:0]      part_bits  = '0;
    int unsigned                part_count = 0;
    logic [DEF_COUNT_WIDTH-1:0] bits_sent  = '0;
    pack_res_t                  due_results [$];

    pack_req_t   stim_q [$];
    pack_req_t   staged;
    pack_req_t   shown;
    bit          staged_ok = 1'b0;
    int unsigned wait_left = 0;
    bit          steady_gaps = 1'b0;

    int unsigned errors = 0;
    int unsigned n_writes = 0;
    int unsigned n_encodes = 0;
    int unsigned n_finishes = 0;
    int unsigned n_ignored = 0;
    int unsigned results_seen = 0;
    int unsigned misses_seen = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;

    function automatic void pack_request(input pack_req_t r);
        int unsigned len;
        int unsigned made;
        int          i;
        logic [63:0] keep;
        pack_res_t   res;
        made = 0;
        res = '0;
        case (r.op)
            OP_WRITE:
            begin
                len = (r.len > DEF_MAX_CODE_LEN) ? DEF_MAX_CODE_LEN : r.len;
                keep = (64'd1 << len) - 64'd1;
                code_words[r.sym] = r.word & keep[WORD_IN_WIDTH-1:0];
                code_lens[r.sym] = len;
                code_set[r.sym] = 1'b1;
            end
            OP_ENCODE:
            begin
                if (!code_set[r.sym])
                begin
                    res.last = 1'b1;
                    res.miss = 1'b1;
                    due_results.insert(due_results.size(), res);
                end
                else
                begin
                    for (i = code_lens[r.sym]; i > 0; i--)
                    begin
                        part_bits = {part_bits[BYTE_WIDTH-2:0], code_words[r.sym][i-1]};
                        part_count++;
                        if (part_count == BYTE_WIDTH)
                        begin
                            res.out_byte = part_bits;
                            res.byte_valid = 1'b1;
                            due_results.insert(due_results.size(), res);
                            made++;
                            part_bits = '0;
                            part_count = 0;
                        end
                        if (bits_sent != TOTAL_MAX)
                            bits_sent++;
                    end
                    if (made > 0)
                    begin
                        res = due_results[due_results.size() - 1];
                        res.last = 1'b1;
                        due_results[due_results.size() - 1] = res;
                    end
                end
            end
            OP_FINISH:
            begin
                res.total = bits_sent;
                res.last = 1'b1;
                if (part_count > 0)
                begin
                    res.out_byte = part_bits << (BYTE_WIDTH - part_count);
                    res.byte_valid = 1'b1;
                end
                due_results.insert(due_results.size(), res);
                part_bits = '0;
                part_count = 0;
                bits_sent = '0;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Request driver: a staged request waits out its gap, and optionally
    // for all outstanding results, before it is offered.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic [S_TDATA_WIDTH-1:0] payload;
        logic                     offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pack_request(shown);
                case (shown.op)
                    OP_WRITE:  n_writes++;
                    OP_ENCODE: n_encodes++;
                    OP_FINISH: n_finishes++;
                    default:   n_ignored++;
                endcase
            end
            if (!s_tvalid || s_tready)
            begin
                offer = 1'b0;
                if (!staged_ok && stim_q.size() > 0)
                begin
                    staged = stim_q.pop_front();
                    staged_ok = 1'b1;
                    wait_left = staged.gap;
                end
                if (staged_ok)
                begin
                    if (wait_left > 0)
                        wait_left--;
                    else if (!staged.drain_first || due_results.size() == 0)
                    begin
                        offer = 1'b1;
                        shown = staged;
                        staged_ok = 1'b0;
                    end
                end
                if (offer)
                begin
                    payload = '0;
                    payload[SYM_LSB +: SYM_WIDTH] = shown.sym;
                    payload[WORD_LSB +: WORD_IN_WIDTH] = shown.word;
                    payload[LEN_LSB +: LEN_IN_WIDTH] = shown.len;
                    s_tdata <= payload;
                    s_tuser <= shown.op;
                end
                s_tvalid <= offer;
            end
        end
    end

    // Receiver: a random stall after each result, none in every third run
    // of forty results, and two long hold-offs that back up the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_seen == 60 || results_seen == 250)
                    stall_left = LONG_HOLD;
                else if ((results_seen / 40) % 3 == 1)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 11);
            end
            else if (stall_left > 0)
                stall_left--;
            m_tready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin : check_proc
        pack_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser[UBIT_MISS])
                misses_seen++;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual byte %0h user %b last %b",
                         $time, m_tdata[BYTE_WIDTH-1:0], m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("out_byte", 64'(want.out_byte), 64'(m_tdata[BYTE_WIDTH-1:0]));
                compare_field("byte_valid", 64'(want.byte_valid),
                              64'(m_tuser[UBIT_BYTE_VALID]));
                compare_field("last", 64'(want.last), 64'(m_tlast));
                compare_field("total_bits", 64'(want.total),
                              64'(m_tdata[BYTE_WIDTH +: DEF_COUNT_WIDTH]));
                compare_field("miss_error", 64'(want.miss), 64'(m_tuser[UBIT_MISS]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(input logic [OP_WIDTH-1:0] op, input logic [SYM_WIDTH-1:0] sym,
                            input logic [WORD_IN_WIDTH-1:0] word,
                            input logic [LEN_IN_WIDTH-1:0] len, input bit drain_first);
        pack_req_t r;
        r.op = op;
        r.sym = sym;
        r.word = word;
        r.len = len;
        r.gap = steady_gaps ? 0 : $urandom_range(0, 11);
        r.drain_first = drain_first;
        stim_q.insert(stim_q.size(), r);
    endtask

    // Mostly short codes as a real tree gives, some long ones, and now and
    // then an empty or over-long length.
    function automatic logic [LEN_IN_WIDTH-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return LEN_IN_WIDTH'($urandom_range(1, 10));
        else if (roll < 90)
            return LEN_IN_WIDTH'($urandom_range(11, 32));
        else if (roll < 95)
            return '0;
        return LEN_IN_WIDTH'($urandom_range(33, 63));
    endfunction

    initial
    begin : stimulus_proc
        bit                     seeded [TABLE_DEPTH];
        logic [SYM_WIDTH-1:0]   pool [$];
        logic [SYM_WIDTH-1:0]   sym;
        int unsigned            counted;
        int unsigned            frame;
        int unsigned            k;
        bit                     drain_now;

        // Directed part: miss on an empty table, an aligned finish with a zero
        // count, extreme codes, the length cut, an empty code, dropped word
        // bits, the unused opcode, multi-byte symbols and padded finishes.
        add_item(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
        add_item(OP_FINISH, 8'h00, 32'h0, 6'd0, 1'b0);
        add_item(OP_WRITE, 8'h00, 32'h0000_0001, 6'd1, 1'b0);
        add_item(OP_WRITE, 8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b0);
        add_item(OP_WRITE, 8'h01, 32'hA5C3_0F96, 6'd63, 1'b0);
        add_item(OP_WRITE, 8'h02, 32'h1234_5678, 6'd0, 1'b0);
        add_item(OP_WRITE, 8'h03, 32'hFFFF_FFF6, 6'd5, 1'b0);
        add_item(OP_WRITE, 8'h04, 32'h0000_0000, 6'd8, 1'b0);
        // The unused opcode must leave entry 0 as it is.
        add_item(OP_UNUSED, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b0);
        add_item(OP_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);
        add_item(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
        add_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
        add_item(OP_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
        add_item(OP_ENCODE, 8'h03, 32'h0, 6'd0, 1'b0);
        add_item(OP_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0);
        add_item(OP_ENCODE, 8'h04, 32'h0, 6'd0, 1'b0);
        add_item(OP_FINISH, 8'h00, 32'h0, 6'd0, 1'b0);
        add_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
        add_item(OP_ENCODE, 8'h80, 32'h0, 6'd0, 1'b0);
        add_item(OP_UNUSED, 8'hFF, 32'h0, 6'd0, 1'b0);
        add_item(OP_FINISH, 8'h00, 32'h0, 6'd0, 1'b1);
        foreach (stim_q[i])
        begin
            if (stim_q[i].op == OP_WRITE && !seeded[stim_q[i].sym])
            begin
                seeded[stim_q[i].sym] = 1'b1;
                pool.insert(pool.size(), stim_q[i].sym);
            end
        end
        counted = stim_q.size() - 2;

        // Random part: frames of table updates and encodes closed by a finish,
        // with the occasional frame left open and some stray opcodes.
        frame = 0;
        while (counted < TARGET_ITEMS)
        begin
            frame++;
            steady_gaps = (frame % 4 == 0);
            drain_now = (frame % 9 == 0);
            k = (pool.size() < 24) ? 6 : $urandom_range(0, 2);
            repeat (k)
            begin
                sym = SYM_WIDTH'($urandom_range(0, 255));
                add_item(OP_WRITE, sym, $urandom, pick_length(), drain_now);
                drain_now = 1'b0;
                counted++;
                if (!seeded[sym])
                begin
                    seeded[sym] = 1'b1;
                    pool.insert(pool.size(), sym);
                end
            end
            repeat ($urandom_range(1, 14))
            begin
                if ($urandom_range(0, 99) < 88)
                    sym = pool[$urandom_range(0, pool.size() - 1)];
                else
                    sym = SYM_WIDTH'($urandom_range(0, 255));
                add_item(OP_ENCODE, sym, $urandom, LEN_IN_WIDTH'($urandom_range(0, 63)),
                         drain_now);
                drain_now = 1'b0;
                counted++;
            end
            if ($urandom_range(0, 19) == 0)
                add_item(OP_UNUSED, SYM_WIDTH'($urandom_range(0, 255)), $urandom,
                         LEN_IN_WIDTH'($urandom_range(0, 63)), 1'b0);
            if ($urandom_range(0, 9) != 0)
            begin
                add_item(OP_FINISH, SYM_WIDTH'($urandom_range(0, 255)), $urandom,
                         LEN_IN_WIDTH'($urandom_range(0, 63)), drain_now);
                counted++;
            end
        end
        add_item(OP_FINISH, 8'h00, 32'h0, 6'd0, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (stim_q.size() > 0 || staged_ok || s_tvalid)
            @(posedge clk);
        while (due_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Requests: %0d table writes, %0d encodes, %0d finishes, %0d unused opcodes.",
                 n_writes, n_encodes, n_finishes, n_ignored);
        $display("Results checked: %0d, of them %0d misses; %0d errors.",
                 results_seen, misses_seen, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/hbp_pkg.sv
rtl/huffman_bit_packer_core.sv
tb/tb.sv
